>>> rtl/core/hmtvn_pkg.sv
// Shared types and constants of the heightmap terrain vertex normal block.
package hmtvn_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [25:0]        pos_x;
    logic signed [15:0] pos_y;
    logic [25:0]        pos_z;
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic [25:0]        tex_u;
    logic [25:0]        tex_v;
    logic               grid_done;
  } out_item_t;

  localparam logic [1:0] REG_GRID_SIDE   = 2'd0;
  localparam logic [1:0] REG_HEIGHT_GAIN = 2'd1;
  localparam logic [1:0] REG_POS_STEP    = 2'd2;
  localparam logic [1:0] REG_UV_STEP     = 2'd3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [10:0] GRID_SIDE_RST   = 11'd64;
  localparam logic [15:0] HEIGHT_GAIN_RST = 16'd256;
  localparam logic [15:0] POS_STEP_RST    = 16'd256;
  localparam logic [15:0] UV_STEP_RST     = 16'd1040;

  // divide/root unit geometry
  localparam int DIVIDEND_W = 62;
  localparam int DIVISOR_W  = 34;
  localparam int QUO_W      = 31;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;

  typedef enum logic {MODE_DIV, MODE_SQRT} ds_mode_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_ctrl_t;

  typedef struct packed {
    logic done;
  } ds_stat_t;

endpackage

>>> rtl/core/hmtvn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hmtvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3072,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/hmtvn_mul.sv
// Shared 16x16 unsigned multiplier with registered product.
module hmtvn_mul (
  input  logic        clk,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [31:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/core/hmtvn_divsqrt.sv
// Iterative restoring divider and integer square root on one shared subtractor.
module hmtvn_divsqrt
  import hmtvn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ds_ctrl_t              ctrl,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output ds_stat_t              stat,
  output logic [QUO_W-1:0]      result
);

  ds_mode_t               mode_r;
  logic [34:0]            rem_r;
  logic [31:0]            sh_r;
  logic [QUO_W-1:0]       quo_r;
  logic [DIVISOR_W-1:0]   div_r;
  logic [4:0]             cnt_r;
  logic                   run_r;
  logic                   done_r;

  logic [34:0] trial;
  logic [34:0] sub_b;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    if (mode_r == MODE_DIV) begin
      trial = {rem_r[33:0], sh_r[31]};
      sub_b = {1'b0, div_r};
    end else begin
      trial = {rem_r[32:0], sh_r[31:30]};
      sub_b = 35'({quo_r, 2'b01});
    end
    diff = {1'b0, trial} - {1'b0, sub_b};
    ge   = ~diff[35];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        mode_r <= ctrl.mode;
        quo_r  <= '0;
        div_r  <= divisor;
        run_r  <= 1'b1;
        if (ctrl.mode == MODE_DIV) begin
          rem_r <= 35'(dividend[DIVIDEND_W-1:QUO_W]);
          sh_r  <= {dividend[QUO_W-1:0], 1'b0};
          cnt_r <= 5'(DIV_STEPS - 1);
        end else begin
          rem_r <= '0;
          sh_r  <= dividend[31:0];
          cnt_r <= 5'(SQRT_STEPS - 1);
        end
      end else if (run_r) begin
        rem_r <= ge ? diff[34:0] : trial;
        quo_r <= {quo_r[QUO_W-2:0], ge};
        sh_r  <= (mode_r == MODE_DIV) ? {sh_r[30:0], 1'b0} : {sh_r[29:0], 2'b00};
        if (cnt_r == 5'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign stat.done = done_r;
  assign result    = quo_r;

endmodule

>>> rtl/core/heightmap_terrain_vertex_normal.sv
// Heightmap terrain vertex generator with central-difference unit normals.
// Pixels enter in raster order; each vertex leaves one row behind its pixel,
// and flush items drain the last row. One item is in work at a time. A pixel
// of the first row passes a height multiply, a bias add, a multiply by the
// reciprocal of 3 and a store write before the next item is taken. A pixel
// that yields a vertex, or a flush that yields one, then goes on: the shared
// divide/root unit runs three 31-step divides and three 16-step roots, plus
// four line store reads and six multiplies (seven for a pixel, with the
// height multiply). Pixels after a full grid and early flushes are dropped.
// The result sits in an output register so the next item is taken while it
// waits; a new vertex stalls only while the previous one has not yet
// transferred.
module heightmap_terrain_vertex_normal
  import hmtvn_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int RW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = 3 * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [27:0] HBIAS = 28'(768 * 32768 + 384);
  // ceil(2^21 / 3): exact floor(x/3) for x below 2^21
  localparam logic [19:0] RECIP3 = 20'd699051;

  typedef enum logic [4:0] {
    S_IDLE, S_HMUL, S_HDIV, S_HDW, S_HWR,
    S_RDC, S_RDL, S_RDR, S_RDD, S_RDE,
    S_MX, S_MZ, S_MPX, S_MPZ, S_MU, S_MV, S_MEND,
    S_DIV, S_DW, S_SW, S_OUT
  } st_t;

  st_t state_r, state_nxt;

  logic [10:0] grid_side_r;
  logic [15:0] gain_r, pstep_r, uvstep_r;

  in_item_t        item_r;
  logic [CW-1:0]   col_r, ecol_r;
  logic [RW-1:0]   row_r, erow_r;
  logic [1:0]      mod_r;
  logic [19:0]     hx_r;
  logic [15:0]     hnew_r, hc_r, hl_r, hr_r, hd_r;
  logic [31:0]     dx2_r, dz2_r;
  logic [33:0]     l2_r;
  logic [25:0]     posx_r, posz_r, texu_r, texv_r;
  logic [1:0]      comp_r;
  logic [15:0]     nx_r, nz_r;
  logic [14:0]     ny_r;
  out_item_t       out_r;
  logic            out_valid_r;

  // side in use, clamped to [2, MAX_SIDE]
  logic [RW-1:0] side;
  always_comb begin
    if (grid_side_r < 11'd2) side = RW'(2);
    else if (32'(grid_side_r) > MAX_SIDE) side = RW'(MAX_SIDE);
    else side = RW'(grid_side_r);
  end

  logic accept, pix_ok, flush_ok, last_col_e, last_col_p, right_off, is_flush;
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign is_flush   = (item_r.req_type == REQ_FLUSH);
  assign pix_ok     = (row_r < side) && (RW'(col_r) < side);
  assign flush_ok   = (row_r == side) && (erow_r == side - RW'(1)) && (RW'(ecol_r) < side);
  assign last_col_e = (RW'(ecol_r) == side - RW'(1));
  assign last_col_p = (RW'(col_r) == side - RW'(1));
  assign right_off  = ((RW+1)'(ecol_r) + (RW+1)'(1)) >= (RW+1)'(side);

  // line store slots: emit row is row_count-1, down row is row_count-2 (mod 3)
  logic [1:0] slot_e, slot_d;
  assign slot_e = (mod_r == 2'd0) ? 2'd2 : mod_r - 2'd1;
  assign slot_d = (mod_r == 2'd2) ? 2'd0 : mod_r + 2'd1;

  function automatic logic [AW-1:0] row_addr(input logic [1:0] slot, input logic [CW-1:0] c);
    logic [AW-1:0] base;
    case (slot)
      2'd0:    base = '0;
      2'd1:    base = AW'(MAX_SIDE);
      default: base = AW'(2 * MAX_SIDE);
    endcase
    return base + AW'(c);
  endfunction

  // line store
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;
  logic          mem_we;
  always_comb begin
    unique case (state_r)
      S_RDL:   raddr = row_addr(slot_e, ecol_r - CW'(1));
      S_RDR:   raddr = row_addr(slot_e, ecol_r + CW'(1));
      S_RDD:   raddr = row_addr(slot_d, ecol_r);
      default: raddr = row_addr(slot_e, ecol_r);
    endcase
  end
  assign mem_we = (state_r == S_HWR);

  hmtvn_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_rows (
    .clk(clk), .we(mem_we), .waddr(row_addr(mod_r, col_r)), .wdata(hnew_r),
    .raddr(raddr), .rdata(rdata)
  );

  // differences
  logic [15:0]        hup;
  logic signed [16:0] dx, dz;
  logic [16:0]        ndx, ndz;
  logic [15:0]        adx, adz;
  assign hup = is_flush ? 16'd0 : hnew_r;
  assign dx  = {hl_r[15], hl_r} - {hr_r[15], hr_r};
  assign dz  = {hd_r[15], hd_r} - {hup[15], hup};
  assign ndx = 17'(-dx);
  assign ndz = 17'(-dz);
  assign adx = dx[16] ? ndx[15:0] : dx[15:0];
  assign adz = dz[16] ? ndz[15:0] : dz[15:0];

  // shared multiplier
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [9:0]  pix_sum;
  assign pix_sum = 10'(item_r.red) + 10'(item_r.green) + 10'(item_r.blue);
  always_comb begin
    unique case (state_r)
      S_HMUL:  begin mul_a = 16'(pix_sum); mul_b = gain_r;  end
      S_MX:    begin mul_a = adx;          mul_b = adx;     end
      S_MZ:    begin mul_a = adz;          mul_b = adz;     end
      S_MPX:   begin mul_a = 16'(ecol_r);  mul_b = pstep_r; end
      S_MPZ:   begin mul_a = 16'(erow_r);  mul_b = pstep_r; end
      S_MU:    begin mul_a = 16'(ecol_r);  mul_b = uvstep_r; end
      S_MV:    begin mul_a = 16'(erow_r);  mul_b = uvstep_r; end
      default: begin mul_a = '0;           mul_b = '0;      end
    endcase
  end

  hmtvn_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // height: t / 768 as (t >> 8) / 3, the divide by 3 by reciprocal multiply
  logic [27:0] hsum;
  logic [39:0] hprod;
  assign hsum  = 28'(mul_p) + HBIAS - 28'({gain_r, 8'b0}) - 28'({gain_r, 7'b0});
  assign hprod = 40'(hx_r) * 40'(RECIP3);

  // divide / root unit
  ds_ctrl_t              ds_ctrl;
  ds_stat_t              ds_stat;
  logic [DIVIDEND_W-1:0] ds_dividend;
  logic [DIVISOR_W-1:0]  ds_divisor;
  logic [QUO_W-1:0]      ds_result;

  always_comb begin
    ds_ctrl.start = (state_r == S_DIV) || ((state_r == S_DW) && ds_stat.done);
    ds_ctrl.mode  = (state_r == S_DW) ? MODE_SQRT : MODE_DIV;
    ds_divisor    = l2_r;
    unique case (state_r)
      S_DW:   ds_dividend = DIVIDEND_W'(ds_result);
      default: begin
        case (comp_r)
          2'd0:    ds_dividend = {dx2_r, 30'b0};
          2'd1:    ds_dividend = DIVIDEND_W'(1) << 48;
          default: ds_dividend = {dz2_r, 30'b0};
        endcase
      end
    endcase
  end

  hmtvn_divsqrt u_ds (
    .clk(clk), .rst_n(rst_n), .ctrl(ds_ctrl), .dividend(ds_dividend),
    .divisor(ds_divisor), .stat(ds_stat), .result(ds_result)
  );

  // round half up: unit = (isqrt + 1) / 2
  logic [17:0] root_rnd;
  logic [14:0] unit_q;
  assign root_rnd = 18'(ds_result[16:0]) + 18'd1;
  assign unit_q   = root_rnd[15:1];

  logic out_load, adv;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign adv      = ((state_r == S_HWR) && (row_r == '0)) || out_load;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        if (in_data.req_type == REQ_PIXEL) state_nxt = pix_ok ? S_HMUL : S_IDLE;
        else state_nxt = flush_ok ? S_RDC : S_IDLE;
      end
      S_HMUL: state_nxt = S_HDIV;
      S_HDIV: state_nxt = S_HDW;
      S_HDW:  state_nxt = S_HWR;
      S_HWR:  state_nxt = (row_r != '0) ? S_RDC : S_IDLE;
      S_RDC:  state_nxt = S_RDL;
      S_RDL:  state_nxt = S_RDR;
      S_RDR:  state_nxt = S_RDD;
      S_RDD:  state_nxt = S_RDE;
      S_RDE:  state_nxt = S_MX;
      S_MX:   state_nxt = S_MZ;
      S_MZ:   state_nxt = S_MPX;
      S_MPX:  state_nxt = S_MPZ;
      S_MPZ:  state_nxt = S_MU;
      S_MU:   state_nxt = S_MV;
      S_MV:   state_nxt = S_MEND;
      S_MEND: state_nxt = S_DIV;
      S_DIV:  state_nxt = S_DW;
      S_DW:   if (ds_stat.done) state_nxt = S_SW;
      S_SW:   if (ds_stat.done) state_nxt = (comp_r == 2'd2) ? S_OUT : S_DIV;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grid_side_r <= GRID_SIDE_RST;
      gain_r      <= HEIGHT_GAIN_RST;
      pstep_r     <= POS_STEP_RST;
      uvstep_r    <= UV_STEP_RST;
      col_r       <= '0;
      row_r       <= '0;
      mod_r       <= '0;
      ecol_r      <= '0;
      erow_r      <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_SIDE:   grid_side_r <= cfg_data[10:0];
          REG_HEIGHT_GAIN: gain_r   <= cfg_data;
          REG_POS_STEP:    pstep_r  <= cfg_data;
          REG_UV_STEP:     uvstep_r <= cfg_data;
          default: ;
        endcase
      end

      if (accept) item_r <= in_data;

      unique case (state_r)
        S_HDIV: hx_r <= hsum[27:8];
        S_HDW:  hnew_r <= {~hprod[36], hprod[35:21]};
        S_RDL:  hc_r <= rdata;
        S_RDR:  hl_r <= (ecol_r == '0) ? 16'd0 : rdata;
        S_RDD:  hr_r <= right_off ? 16'd0 : rdata;
        S_RDE:  hd_r <= (erow_r == '0) ? 16'd0 : rdata;
        S_MZ:   dx2_r <= mul_p;
        S_MPX:  dz2_r <= mul_p;
        S_MPZ:  posx_r <= mul_p[25:0];
        S_MU:   posz_r <= mul_p[25:0];
        S_MV:   texu_r <= mul_p[25:0];
        S_MEND: begin
          texv_r <= mul_p[25:0];
          l2_r   <= 34'(dx2_r) + 34'(dz2_r) + 34'(262144);
          comp_r <= 2'd0;
        end
        S_SW: if (ds_stat.done) begin
          case (comp_r)
            2'd0:    nx_r <= dx[16] ? 16'd0 - 16'(unit_q) : 16'(unit_q);
            2'd1:    ny_r <= unit_q;
            default: nz_r <= dz[16] ? 16'd0 - 16'(unit_q) : 16'(unit_q);
          endcase
          comp_r <= comp_r + 2'd1;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r     <= 1'b1;
        out_r.pos_x     <= posx_r;
        out_r.pos_y     <= hc_r;
        out_r.pos_z     <= posz_r;
        out_r.normal_x  <= nx_r;
        out_r.normal_y  <= ny_r;
        out_r.normal_z  <= nz_r;
        out_r.tex_u     <= texu_r;
        out_r.tex_v     <= texv_r;
        out_r.grid_done <= is_flush && last_col_e;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // a grid side write restarts the grid
      if (cfg_we && (cfg_index == REG_GRID_SIDE)) begin
        col_r  <= '0;
        row_r  <= '0;
        mod_r  <= '0;
        ecol_r <= '0;
        erow_r <= '0;
      end else if (adv) begin
        if (is_flush) begin
          if (last_col_e) begin
            col_r  <= '0;
            row_r  <= '0;
            mod_r  <= '0;
            ecol_r <= '0;
            erow_r <= '0;
          end else begin
            ecol_r <= ecol_r + CW'(1);
          end
        end else begin
          if (row_r != '0) begin
            if (last_col_e) begin
              ecol_r <= '0;
              erow_r <= erow_r + RW'(1);
            end else begin
              ecol_r <= ecol_r + CW'(1);
            end
          end
          if (last_col_p) begin
            col_r <= '0;
            row_r <= row_r + RW'(1);
            mod_r <= (mod_r == 2'd2) ? 2'd0 : mod_r + 2'd1;
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pixel column never runs past the grid
  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    RW'(col_r) < side)
    else $error("column count beyond grid side");

  // while rows stream in, the emit column tracks the pixel column
  a_emit_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r != '0) && (row_r < side) |-> (ecol_r == col_r))
    else $error("emit position lost step with input position");

  // the divide/root unit reports only while the sequencer waits on it
  a_ds_done: assert property (@(posedge clk) disable iff (!rst_n)
    ds_stat.done |-> (state_r == S_HDW) || (state_r == S_DW) || (state_r == S_SW))
    else $error("divide/root result arrived outside a wait state");

  // a new result is loaded only once the previous transfer has happened
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && (state_r == S_OUT) |=> state_r == S_OUT)
    else $error("result register overwritten before transfer");

endmodule

>>> dv/tb_heightmap_terrain_vertex_normal.sv
// Testbench for the heightmap terrain vertex normal block: predictor, stimulus and checks.
`timescale 1ns / 100ps

module tb_heightmap_terrain_vertex_normal;
  import hmtvn_pkg::*;

  localparam int MAX_SIDE   = 1024;
  localparam int DRAIN_WAIT = 400;
  localparam longint CYCLE_LIMIT = 6000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  heightmap_terrain_vertex_normal #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // predictor state
  logic [10:0] side_reg;
  logic [15:0] gain_reg, pstep_reg, uvstep_reg;
  logic [15:0] height_store [3*MAX_SIDE];
  int unsigned pix_col, pix_row, vtx_col, vtx_row;

  out_item_t vertex_q[$];
  int        mismatches;
  int        idle_pct, stall_pct, hold_cycles;
  longint    cycles;

  function automatic int unsigned active_side();
    if (side_reg < 2) return 2;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  function automatic logic [15:0] height_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned sum, t;
    sum = longint'(r) + longint'(g) + longint'(b);
    t = sum * gain_reg + 384 + 768 * 32768 - 384 * longint'(gain_reg);
    return 16'((t / 768) - 32768);
  endfunction

  function automatic int height_at(int r, int c, int unsigned side);
    if (r < 0 || c < 0 || r >= side || c >= side) return 0;
    return int'($signed(height_store[(r % 3) * MAX_SIDE + c]));
  endfunction

  // round(16384*mag/sqrt(l2)), ties up, by bisection on (2q-1)^2*l2 <= (2*16384*mag)^2
  function automatic int unsigned unit_len(longint unsigned mag, longint unsigned l2);
    longint unsigned scaled, rhs, t;
    int unsigned lo, hi, mid;
    scaled = mag * 32768;
    rhs = scaled * scaled;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * longint'(mid) - 1;
      if (t * t * l2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [15:0] signed_len(int d, longint unsigned l2);
    int unsigned q;
    q = unit_len(d < 0 ? -d : d, l2);
    return d < 0 ? 16'(-int'(q)) : 16'(q);
  endfunction

  function automatic out_item_t vertex_at(int unsigned row, int unsigned col,
                                          int unsigned side, bit last);
    out_item_t v;
    int dx, dz;
    longint unsigned l2;
    dx = height_at(row, col - 1, side) - height_at(row, col + 1, side);
    dz = height_at(row - 1, col, side) - height_at(row + 1, col, side);
    l2 = longint'(dx) * dx + 512 * 512 + longint'(dz) * dz;
    v.pos_x     = 26'(longint'(col) * pstep_reg);
    v.pos_y     = 16'(height_at(row, col, side));
    v.pos_z     = 26'(longint'(row) * pstep_reg);
    v.normal_x  = signed_len(dx, l2);
    v.normal_y  = 15'(unit_len(512, l2));
    v.normal_z  = signed_len(dz, l2);
    v.tex_u     = 26'(longint'(col) * uvstep_reg);
    v.tex_v     = 26'(longint'(row) * uvstep_reg);
    v.grid_done = last;
    return v;
  endfunction

  function automatic void clear_position();
    pix_col = 0; pix_row = 0; vtx_col = 0; vtx_row = 0;
  endfunction

  function automatic void expect_vertex(out_item_t v);
    vertex_q.insert(vertex_q.size(), v);
  endfunction

  function automatic void predict_item(in_item_t it);
    int unsigned side;
    side = active_side();
    if (it.req_type == REQ_PIXEL) begin
      if (pix_row >= side || pix_col >= side) return;
      height_store[(pix_row % 3) * MAX_SIDE + pix_col] = height_of(it.red, it.green, it.blue);
      if (pix_row >= 1) begin
        expect_vertex(vertex_at(vtx_row, vtx_col, side, 1'b0));
        vtx_col++;
        if (vtx_col >= side) begin
          vtx_col = 0;
          vtx_row++;
        end
      end
      pix_col++;
      if (pix_col >= side) begin
        pix_col = 0;
        pix_row++;
      end
    end else begin
      if (pix_row != side || vtx_row != side - 1 || vtx_col >= side) return;
      if (vtx_col == side - 1) begin
        expect_vertex(vertex_at(vtx_row, vtx_col, side, 1'b1));
        clear_position();
      end else begin
        expect_vertex(vertex_at(vtx_row, vtx_col, side, 1'b0));
        vtx_col++;
      end
    end
  endfunction

  function automatic void check_vertex(out_item_t got);
    out_item_t exp;
    if (vertex_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected vertex: %p", got);
      return;
    end
    exp = vertex_q.pop_front();
    if (got.pos_x !== exp.pos_x || got.pos_y !== exp.pos_y || got.pos_z !== exp.pos_z ||
        got.normal_x !== exp.normal_x || got.normal_y !== exp.normal_y ||
        got.normal_z !== exp.normal_z || got.tex_u !== exp.tex_u ||
        got.tex_v !== exp.tex_v || got.grid_done !== exp.grid_done) begin
      mismatches++;
      if (mismatches <= 10) $display("vertex mismatch\n  exp %p\n  got %p", exp, got);
    end
  endfunction

  // monitor: register writes, input transfers, output transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_SIDE: begin
            side_reg = cfg_data[10:0];
            clear_position();
          end
          REG_HEIGHT_GAIN: gain_reg = cfg_data;
          REG_POS_STEP:    pstep_reg = cfg_data;
          REG_UV_STEP:     uvstep_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_item(in_data);
      if (out_valid && out_ready) check_vertex(out_data);
    end
  end

  // receiver: random stalls plus a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** heightmap_terrain_vertex_normal: FAILED **");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_item('{req_type: REQ_PIXEL, red: r, green: g, blue: b});
  endtask

  task automatic send_flush();
    send_item('{req_type: REQ_FLUSH, red: 8'($urandom), green: 8'($urandom),
                blue: 8'($urandom)});
  endtask

  task automatic send_random_pixel();
    case ($urandom_range(7))
      0: send_pixel(8'h00, 8'h00, 8'h00);
      1: send_pixel(8'hff, 8'hff, 8'hff);
      default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  // wait until every vertex is out and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic full_grid(int unsigned n);
    repeat (n * n) send_random_pixel();
    repeat (n) send_flush();
  endtask

  task automatic test_directed();
    idle_pct = 0; stall_pct = 0;
    write_reg(REG_HEIGHT_GAIN, 16'hffff);
    write_reg(REG_POS_STEP, 16'hffff);
    write_reg(REG_UV_STEP, 16'hffff);
    write_reg(REG_GRID_SIDE, 16'd0);   // clamps up to 2
    send_flush();                       // early flush, dropped
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_flush();                       // still early
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h55, 8'haa, 8'h01);    // past the full grid, dropped
    send_flush();
    send_flush();                       // last vertex of the grid
    send_flush();                       // counters already cleared, dropped
    write_reg(REG_HEIGHT_GAIN, 16'h0000);
    write_reg(REG_POS_STEP, 16'h0000);
    write_reg(REG_UV_STEP, 16'h0000);
    write_reg(REG_GRID_SIDE, 16'd1);
    full_grid(2);
    write_reg(REG_HEIGHT_GAIN, 16'h8000);
    write_reg(REG_GRID_SIDE, 16'd3);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    repeat (3) send_random_pixel();
    // side write in the middle of a grid restarts it
    write_reg(REG_GRID_SIDE, 16'd3);
    full_grid(3);
  endtask

  // widest grid: first rows only, then abandoned by a side write
  task automatic test_widest_grid();
    idle_pct = 0; stall_pct = 0;
    write_reg(REG_POS_STEP, 16'hffff);
    write_reg(REG_UV_STEP, 16'hffff);
    write_reg(REG_HEIGHT_GAIN, 16'(480));
    write_reg(REG_GRID_SIDE, 16'h07ff);
    repeat (MAX_SIDE + 6) send_random_pixel();
    write_reg(REG_GRID_SIDE, 16'd2);
    full_grid(2);
  endtask

  task automatic test_backpressure();
    idle_pct = 0; stall_pct = 0;
    write_reg(REG_GRID_SIDE, 16'd3);
    hold_cycles = 3000;
    full_grid(3);
    drain();
    // sender waits for every vertex before going on
    write_reg(REG_GRID_SIDE, 16'd4);
    repeat (6) send_random_pixel();
    drain();
    repeat (10) send_random_pixel();
    repeat (4) send_flush();
  endtask

  task automatic test_random(int items);
    int sent, side, k;
    sent = 0;
    k = 0;
    while (sent < items) begin
      case (k % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      k++;
      if ($urandom_range(2) == 0) write_reg(REG_HEIGHT_GAIN, 16'($urandom));
      if ($urandom_range(3) == 0) write_reg(REG_POS_STEP, 16'($urandom));
      if ($urandom_range(3) == 0) write_reg(REG_UV_STEP, 16'($urandom));
      side = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(2, 7);
      write_reg(REG_GRID_SIDE, 16'(side));
      if ($urandom_range(9) == 0) begin
        // broken grid: partial rows with stray flushes, then restarted
        repeat ($urandom_range(1, side * side)) begin
          if ($urandom_range(5) == 0) send_flush();
          else send_random_pixel();
          sent++;
        end
        write_reg(REG_GRID_SIDE, 16'(side));
      end
      for (int i = 0; i < side * side; i++) begin
        if ($urandom_range(15) == 0) begin
          send_flush();
          sent++;
        end
        send_random_pixel();
      end
      if ($urandom_range(3) == 0) begin
        send_random_pixel();
        sent++;
      end
      repeat (side) send_flush();
      sent += side * side + side;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_SIDE;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    cycles = 0;
    mismatches = 0;
    side_reg = GRID_SIDE_RST;
    gain_reg = HEIGHT_GAIN_RST;
    pstep_reg = POS_STEP_RST;
    uvstep_reg = UV_STEP_RST;
    foreach (height_store[i]) height_store[i] = '0;
    clear_position();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first
    full_grid(3);
    test_directed();
    test_widest_grid();
    test_backpressure();
    test_random(900);
    drain();

    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("** heightmap_terrain_vertex_normal: PASSED **");
    end else begin
      $display("** heightmap_terrain_vertex_normal: FAILED **");
    end
    $finish;
  end

endmodule
